>>> rtl/lwsc_pkg.sv
// ----------------------------------------------------------------------------
// lwsc_pkg
// Shared types, codes and defaults for the sector cache tag block.
// ----------------------------------------------------------------------------
package lwsc_pkg;

	localparam int WAYS_DEF              = 32;
	localparam int SECTOR_BYTES_DEF      = 4096;
	localparam int FILES_DEF             = 16;
	localparam int SECTOR_INDEX_BITS_DEF = 20;

	localparam int FID_W   = 4;
	localparam int SEC_W   = 20;
	localparam int LEN_W   = 32;
	localparam int WAY_W   = 5;
	localparam int BYTES_W = 13;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_FLUSH   = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	localparam logic [1:0] KIND_ACCESS = 2'd0;
	localparam logic [1:0] KIND_WB     = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [1:0] MAP_NONE     = 2'd0;
	localparam logic [1:0] MAP_MAPPED   = 2'd1;
	localparam logic [1:0] MAP_MODIFIED = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [FID_W-1:0] file_id;
		logic [SEC_W-1:0] sector_index;
		logic [LEN_W-1:0] file_length;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [WAY_W-1:0]   way;
		logic               hit;
		logic               fill;
		logic [FID_W-1:0]   wb_file;
		logic [SEC_W-1:0]   wb_sector;
		logic [BYTES_W-1:0] wb_bytes;
		logic               last;
	} rsp_item_t;

	// request to the clip unit
	typedef struct packed {
		logic             load;
		logic [SEC_W-1:0] sector;
		logic [LEN_W-1:0] len;
	} clip_req_t;

	// answer of the clip unit, valid the cycle after load
	typedef struct packed {
		logic               need;
		logic [BYTES_W-1:0] bytes;
	} clip_rsp_t;

endpackage

>>> rtl/lwsc_if.sv
// ----------------------------------------------------------------------------
// lwsc_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface lwsc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lru_writeback_sector_cache_tags.sv
// ----------------------------------------------------------------------------
// lru_writeback_sector_cache_tags
// Tag and LRU store of a fully associative write-back sector cache.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | role
//  req     | in  | cmd, file_id, sector_index, file_length          | access / flush
//  rsp     | out | kind, way, hit, fill, wb_file, wb_sector, ...    | results, last marks end
//
//  one transaction in at a time: req.ready is high only while the sequencer is idle
//  access: capture, file id reduce, way search from the head, victim write-back if dirty, result
//  flush: capture, file id reduce, way walk (offset multiply and clip per dirty way
//         of the file), tail compaction sweep, done; unmapped or clean flush skips the walk
//  the walks step one way per cycle, apart from the dirty-way steps; rsp stalls hold the sequencer
//  reset clears valid, dirty, map state and lru order (way i at position i)
module lru_writeback_sector_cache_tags #(
	parameter int WAYS              = lwsc_pkg::WAYS_DEF,
	parameter int SECTOR_BYTES      = lwsc_pkg::SECTOR_BYTES_DEF,
	parameter int FILES             = lwsc_pkg::FILES_DEF,
	parameter int SECTOR_INDEX_BITS = lwsc_pkg::SECTOR_INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lwsc_if.sink   req,
	lwsc_if.source rsp
);
	localparam int WB = $clog2(WAYS);
	localparam int PB = $clog2(WAYS + 1);
	localparam int FB = (FILES > 1) ? $clog2(FILES) : 1;
	localparam int SW = (SECTOR_INDEX_BITS < lwsc_pkg::SEC_W) ? SECTOR_INDEX_BITS
	                                                         : lwsc_pkg::SEC_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RED   = 4'd1;
	localparam logic [3:0] ST_AWALK = 4'd2;
	localparam logic [3:0] ST_AVICT = 4'd3;
	localparam logic [3:0] ST_ARES  = 4'd4;
	localparam logic [3:0] ST_FWALK = 4'd5;
	localparam logic [3:0] ST_FMUL  = 4'd6;
	localparam logic [3:0] ST_FCLIP = 4'd7;
	localparam logic [3:0] ST_FSWP  = 4'd8;
	localparam logic [3:0] ST_FDONE = 4'd9;

	// tag store
	logic [WB-1:0]              lru_q   [WAYS];
	logic [WB-1:0]              moved_q [WAYS];
	logic [lwsc_pkg::FID_W-1:0] file_q  [WAYS];
	logic [SW-1:0]              sec_q   [WAYS];
	logic [WAYS-1:0]            valid_q;
	logic [WAYS-1:0]            dirty_q;
	logic [1:0]                 map_q   [FILES];

	// sequencer
	logic [3:0]                 state_q;
	logic [1:0]                 cmd_q;
	logic [lwsc_pkg::FID_W-1:0] fid_q;
	logic [SW-1:0]              sin_q;
	logic [lwsc_pkg::LEN_W-1:0] len_q;
	logic [PB-1:0]              pos_q;
	logic [PB-1:0]              nm_q;
	logic [WB-1:0]              w_q;
	logic                       hit_q;
	logic                       out_v_q;
	lwsc_pkg::rsp_item_t        out_q;

	logic [WB-1:0]       cur_w;
	logic [PB:0]         sum;
	logic                can_emit;
	logic [FB-1:0]       fidx;
	logic                tag_eq;
	logic                is_wr;
	logic                is_all;
	lwsc_pkg::clip_req_t creq;
	lwsc_pkg::clip_rsp_t crsp;

	assign cur_w    = lru_q[pos_q[WB-1:0]];
	assign sum      = (PB+1)'(pos_q) + (PB+1)'(nm_q);
	assign can_emit = !out_v_q || rsp.ready;
	assign fidx     = FB'(fid_q);
	assign tag_eq   = (file_q[cur_w] == fid_q) && (sec_q[cur_w] == sin_q);
	assign is_wr    = (cmd_q == lwsc_pkg::CMD_WRITE);
	assign is_all   = (cmd_q == lwsc_pkg::CMD_RELEASE);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	assign creq.load   = (state_q == ST_FWALK);
	assign creq.sector = lwsc_pkg::SEC_W'(sec_q[cur_w]);
	assign creq.len    = len_q;

	lwsc_clip #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.SW          (SW)
	) u_clip (
		.clk(clk),
		.req(creq),
		.rsp(crsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < WAYS; i++) begin
				lru_q[i] <= WB'(i);
			end
			for (int f = 0; f < FILES; f++) begin
				map_q[f] <= lwsc_pkg::MAP_NONE;
			end
		end else begin
			// result register drains on its transaction
			if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.data.cmd;
						fid_q   <= req.data.file_id;
						sin_q   <= req.data.sector_index[SW-1:0];
						len_q   <= req.data.file_length;
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					// file id modulo the number of files, one subtract per cycle
					if (int'(fid_q) >= FILES) begin
						fid_q <= lwsc_pkg::FID_W'(int'(fid_q) - FILES);
					end else begin
						pos_q <= '0;
						nm_q  <= '0;
						if (cmd_q == lwsc_pkg::CMD_READ || cmd_q == lwsc_pkg::CMD_WRITE) begin
							state_q <= ST_AWALK;
						end else if (map_q[fidx] == lwsc_pkg::MAP_NONE ||
						             (map_q[fidx] == lwsc_pkg::MAP_MAPPED && !is_all)) begin
							state_q <= ST_FDONE;
						end else begin
							if (map_q[fidx] != 2'd3) begin
								map_q[fidx] <= is_all ? lwsc_pkg::MAP_NONE : lwsc_pkg::MAP_MAPPED;
							end
							state_q <= ST_FWALK;
						end
					end
				end
				ST_AWALK: begin
					// search from the head, stop at a hit, a free way or the tail
					if (!valid_q[cur_w] || tag_eq || pos_q == PB'(WAYS - 1)) begin
						w_q   <= cur_w;
						hit_q <= valid_q[cur_w] && tag_eq;
						for (int i = 1; i < WAYS; i++) begin
							if (PB'(i) <= pos_q) begin
								lru_q[i] <= lru_q[i-1];
							end
						end
						lru_q[0] <= cur_w;
						state_q  <= ST_AVICT;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_AVICT: begin
					if (hit_q || !valid_q[w_q] || !dirty_q[w_q]) begin
						state_q <= ST_ARES;
					end else if (can_emit) begin
						out_v_q         <= 1'b1;
						out_q           <= '0;
						out_q.kind      <= lwsc_pkg::KIND_WB;
						out_q.way       <= lwsc_pkg::WAY_W'(w_q);
						out_q.wb_file   <= file_q[w_q];
						out_q.wb_sector <= lwsc_pkg::SEC_W'(sec_q[w_q]);
						out_q.wb_bytes  <= lwsc_pkg::BYTES_W'(SECTOR_BYTES);
						state_q         <= ST_ARES;
					end
				end
				ST_ARES: begin
					if (can_emit) begin
						if (!hit_q) begin
							file_q[w_q]  <= fid_q;
							sec_q[w_q]   <= sin_q;
							valid_q[w_q] <= 1'b1;
						end
						// a fill takes the access type, a write hit turns dirty
						if (!hit_q || is_wr) begin
							dirty_q[w_q] <= is_wr;
						end
						if (is_wr) begin
							map_q[fidx]  <= lwsc_pkg::MAP_MODIFIED;
						end else if (map_q[fidx] == lwsc_pkg::MAP_NONE) begin
							map_q[fidx] <= lwsc_pkg::MAP_MAPPED;
						end
						out_v_q    <= 1'b1;
						out_q      <= '0;
						out_q.kind <= lwsc_pkg::KIND_ACCESS;
						out_q.way  <= lwsc_pkg::WAY_W'(w_q);
						out_q.hit  <= hit_q;
						out_q.fill <= !hit_q;
						out_q.last <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_FWALK: begin
					// walk to the first free way; kept ways compact toward the head
					if (pos_q == PB'(WAYS) || !valid_q[cur_w]) begin
						pos_q   <= pos_q - nm_q;
						state_q <= (pos_q - nm_q == PB'(WAYS)) ? ST_FDONE : ST_FSWP;
					end else if (file_q[cur_w] == fid_q) begin
						w_q <= cur_w;
						if (dirty_q[cur_w]) begin
							state_q <= ST_FMUL;
						end else begin
							valid_q[cur_w]          <= 1'b0;
							moved_q[nm_q[WB-1:0]]   <= cur_w;
							nm_q                    <= nm_q + 1'b1;
							pos_q                   <= pos_q + 1'b1;
						end
					end else begin
						lru_q[WB'(pos_q - nm_q)] <= cur_w;
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_FMUL: begin
					state_q <= ST_FCLIP;
				end
				ST_FCLIP: begin
					if (!crsp.need || can_emit) begin
						if (crsp.need) begin
							out_v_q         <= 1'b1;
							out_q           <= '0;
							out_q.kind      <= lwsc_pkg::KIND_WB;
							out_q.way       <= lwsc_pkg::WAY_W'(w_q);
							out_q.wb_file   <= file_q[w_q];
							out_q.wb_sector <= lwsc_pkg::SEC_W'(sec_q[w_q]);
							out_q.wb_bytes  <= crsp.bytes;
						end
						valid_q[w_q]          <= 1'b0;
						dirty_q[w_q]          <= 1'b0;
						moved_q[nm_q[WB-1:0]] <= w_q;
						nm_q                  <= nm_q + 1'b1;
						pos_q                 <= pos_q + 1'b1;
						state_q               <= ST_FWALK;
					end
				end
				ST_FSWP: begin
					// close the gap, then append invalidated ways at the tail
					if (sum < (PB+1)'(WAYS)) begin
						lru_q[pos_q[WB-1:0]] <= lru_q[sum[WB-1:0]];
					end else begin
						lru_q[pos_q[WB-1:0]] <= moved_q[WB'(sum - (PB+1)'(WAYS))];
					end
					pos_q <= pos_q + 1'b1;
					if (pos_q == PB'(WAYS - 1)) begin
						state_q <= ST_FDONE;
					end
				end
				ST_FDONE: begin
					if (can_emit) begin
						out_v_q    <= 1'b1;
						out_q      <= '0;
						out_q.kind <= lwsc_pkg::KIND_DONE;
						out_q.last <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/lwsc_clip.sv
// ----------------------------------------------------------------------------
// lwsc_clip
// Sector offset multiply, then length compare and clip to one sector.
// ----------------------------------------------------------------------------
module lwsc_clip #(
	parameter int SECTOR_BYTES = lwsc_pkg::SECTOR_BYTES_DEF,
	parameter int SW           = lwsc_pkg::SEC_W
) (
	input  logic                clk,
	input  lwsc_pkg::clip_req_t req,
	output lwsc_pkg::clip_rsp_t rsp
);
	localparam int SBW = $clog2(SECTOR_BYTES + 1);
	localparam int OW  = SW + SBW;
	localparam int DW  = ((OW > lwsc_pkg::LEN_W) ? OW : lwsc_pkg::LEN_W) + 1;

	logic [OW-1:0] off_q;
	logic [DW-1:0] diff;

	// byte offset of the sector start
	always_ff @(posedge clk) begin
		if (req.load) begin
			off_q <= OW'(req.sector[SW-1:0]) * OW'(SECTOR_BYTES);
		end
	end

	assign diff = DW'(req.len) - DW'(off_q);

	always_comb begin
		rsp.need  = !diff[DW-1] && (diff != '0);
		rsp.bytes = (diff > DW'(SECTOR_BYTES)) ? lwsc_pkg::BYTES_W'(SECTOR_BYTES)
		                                       : lwsc_pkg::BYTES_W'(diff);
	end
endmodule
